FILE: rtl/lodj_pkg.sv
// Shared types and codes for the per-label overlap counter block.
// No dependencies.
`timescale 1ns / 1ps

package lodj_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_ACCUM = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Field positions inside one counter entry
  localparam int FLD_A  = 0;
  localparam int FLD_B  = 1;
  localparam int FLD_OV = 2;
  localparam int FLD_UN = 3;
  localparam int NUM_FLDS = 4;

  // Increment masks, one bit per field
  localparam logic [NUM_FLDS-1:0] INC_A   = 4'b0001;
  localparam logic [NUM_FLDS-1:0] INC_B   = 4'b0010;
  localparam logic [NUM_FLDS-1:0] INC_OV  = 4'b0100;
  localparam logic [NUM_FLDS-1:0] INC_UN  = 4'b1000;
  localparam logic [NUM_FLDS-1:0] INC_ALL = 4'b1111;

  localparam int LABEL_W = 12;
  localparam int CNT_OUT_W = 32;
  localparam int RATIO_OUT_W = 17;

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_WR1  = 7'b0000100,
    ST_WR2  = 7'b0001000,
    ST_QRD  = 7'b0010000,
    ST_QSET = 7'b0100000,
    ST_DIV  = 7'b1000000
  } state_e;

endpackage

FILE: rtl/label_overlap_dice_jaccard.sv
// Per-label overlap counters (A, B, overlap, union) with Dice / Jaccard query.
// Depends on lodj_pkg.
`timescale 1ns / 1ps

// Channel  Dir  Handshake                 Payload
// -------  ---  ------------------------  ------------------------------------
// in       in   in_valid_i / in_stall_o   kind_i, label_a_i, label_b_i
// out      out  out_valid_o / out_stall_i label_o, volume_a_o, volume_b_o,
//                                         overlap_o, union_count_o, dice_o,
//                                         jaccard_o, present_o
//
// All counters live in one RAM of NUM_LABELS entries with one read port and
// one write port, each entry holding the four counters side by side; reads
// are registered.
// Accumulate: one entry is touched if both labels are the same (or only one is
// in range), two otherwise (read/modify/write each); the next item is taken
// during the write of the last one. Query: read, capture (QRD), set-up (QSET),
// then the two bit-serial dividers (DIV, FRACTION_BITS + 1 steps); no item is
// taken until the result is loaded. Clear item and reset: a sweep over all
// NUM_LABELS entries writing zero, one entry per cycle, with no item taken.
// A finished query result sits in the output register until taken; the next
// query waits only at its end if that register is still full.

module label_overlap_dice_jaccard
  import lodj_pkg::*;
#(
  parameter int NUM_LABELS    = 4096,
  parameter int COUNT_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             kind_i,
  input  logic [LABEL_W-1:0]     label_a_i,
  input  logic [LABEL_W-1:0]     label_b_i,

  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [LABEL_W-1:0]     label_o,
  output logic [CNT_OUT_W-1:0]   volume_a_o,
  output logic [CNT_OUT_W-1:0]   volume_b_o,
  output logic [CNT_OUT_W-1:0]   overlap_o,
  output logic [CNT_OUT_W-1:0]   union_count_o,
  output logic [RATIO_OUT_W-1:0] dice_o,
  output logic [RATIO_OUT_W-1:0] jaccard_o,
  output logic                   present_o
);

  localparam int AW   = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
  localparam int CMPW = ((AW > LABEL_W) ? AW : LABEL_W) + 1;
  localparam int CW   = COUNT_BITS;
  localparam int DW   = CW + 2;              // divider remainder width
  localparam int QW   = FRACTION_BITS + 1;   // raw quotient bits
  localparam int SW   = $clog2(QW + 1);      // step counter width
  localparam int EW   = NUM_FLDS * CW;       // RAM entry width

  typedef logic [NUM_FLDS-1:0][CW-1:0] entry_t;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic [CMPW-1:0] la_ext, lb_ext;
  logic [AW-1:0]   la_idx, lb_idx;
  logic            la_ok, lb_ok, same_lbl;

  assign la_ext   = CMPW'(label_a_i);
  assign lb_ext   = CMPW'(label_b_i);
  assign la_ok    = la_ext < CMPW'(NUM_LABELS);
  assign lb_ok    = lb_ext < CMPW'(NUM_LABELS);
  assign la_idx   = la_ext[AW-1:0];
  assign lb_idx   = lb_ext[AW-1:0];
  assign same_lbl = (label_a_i == label_b_i);

  // Entries an accumulate item touches: a first and an optional second one
  logic                acc_h1, acc_h2;
  logic [AW-1:0]       acc_t1, acc_t2;
  logic [NUM_FLDS-1:0] acc_m1, acc_m2;

  always_comb begin
    acc_h1 = 1'b0;
    acc_h2 = 1'b0;
    acc_t1 = la_idx;
    acc_t2 = lb_idx;
    acc_m1 = INC_ALL;
    acc_m2 = INC_B | INC_UN;
    if (same_lbl) begin
      acc_h1 = la_ok;
    end else if (la_ok) begin
      acc_h1 = 1'b1;
      acc_m1 = INC_A | INC_UN;
      acc_h2 = lb_ok;
    end else begin
      // A label out of range: the B entry is touched only if B is in range
      acc_h1 = lb_ok;
      acc_t1 = lb_idx;
      acc_m1 = INC_B | INC_UN;
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [AW-1:0]       clr_addr_q, clr_addr_d;
  logic [AW-1:0]       t1_q, t2_q;
  logic [NUM_FLDS-1:0] m1_q, m2_q;
  logic                h2_q;
  logic [LABEL_W-1:0]  qlbl_q;
  logic                qok_q;

  logic can_accept, accept;
  assign can_accept = (state_q == ST_IDLE) || (state_q == ST_WR2) ||
                      ((state_q == ST_WR1) && !h2_q);
  assign in_stall_o = !can_accept;
  assign accept     = in_valid_i && can_accept;

  // ---------------------------------------------------------------------------
  // Counter RAM with write-to-read forwarding
  // ---------------------------------------------------------------------------
  logic [EW-1:0] mem_q [NUM_LABELS];
  logic [EW-1:0] mem_rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata;
  logic          fwd_q;
  logic [EW-1:0] fwd_data_q;
  entry_t        rd_entry;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // a read issued in the same cycle as a write to its entry sees the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= mem_we && mem_re && (mem_waddr == mem_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= mem_wdata;
  end

  assign rd_entry = fwd_q ? entry_t'(fwd_data_q) : entry_t'(mem_rdata_q);

  // saturating increment of the masked fields
  entry_t upd_entry;
  always_comb begin
    logic [NUM_FLDS-1:0] msk;
    msk = (state_q == ST_WR2) ? m2_q : m1_q;
    for (int f = 0; f < NUM_FLDS; f++) begin
      upd_entry[f] = rd_entry[f];
      if (msk[f] && (rd_entry[f] != {CW{1'b1}})) begin
        upd_entry[f] = rd_entry[f] + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;

  logic [SW-1:0] step_q;
  logic          div_done;
  assign div_done = (step_q == SW'(QW));

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = acc_t1;

    case (state_q)
      ST_CLR: begin
        mem_we = 1'b1;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(NUM_LABELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
      end
      ST_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = t1_q;
        mem_wdata = EW'(upd_entry);
        if (h2_q) begin
          mem_re    = 1'b1;
          mem_raddr = t2_q;
          state_d   = ST_WR2;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = t2_q;
        mem_wdata = EW'(upd_entry);
        state_d   = ST_IDLE;
      end
      ST_QRD: begin
        state_d = ST_QSET;
      end
      ST_QSET: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a new item overrides the fall-back to idle
    if (accept) begin
      case (kind_i)
        KIND_ACCUM: begin
          mem_re    = acc_h1;
          mem_raddr = acc_t1;
          state_d   = acc_h1 ? ST_WR1 : ST_IDLE;
        end
        KIND_QUERY: begin
          mem_re    = la_ok;
          mem_raddr = la_idx;
          state_d   = ST_QRD;
        end
        KIND_CLEAR: begin
          clr_addr_d = '0;
          state_d    = ST_CLR;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      clr_addr_q <= '0;
      h2_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      if (accept) begin
        h2_q <= (kind_i == KIND_ACCUM) && acc_h2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      t1_q   <= acc_t1;
      t2_q   <= acc_t2;
      m1_q   <= acc_m1;
      m2_q   <= acc_m2;
      qlbl_q <= label_a_i;
      qok_q  <= la_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Query path: capture, set up two restoring dividers, round
  // ---------------------------------------------------------------------------
  entry_t cnt_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_QRD) begin
      cnt_q <= qok_q ? rd_entry : entry_t'('0);
    end
  end

  // unit 0: dice = 2*ov / (a+b), unit 1: jaccard = ov / un
  logic [1:0][DW-1:0] num_set, den_set;
  assign num_set[0] = {cnt_q[FLD_OV], 1'b0} & DW'({(CW + 1){1'b1}});
  assign den_set[0] = DW'(cnt_q[FLD_A]) + DW'(cnt_q[FLD_B]);
  assign num_set[1] = DW'(cnt_q[FLD_OV]);
  assign den_set[1] = DW'(cnt_q[FLD_UN]);

  logic [1:0][DW-1:0] rem_q, den_q;
  logic [1:0][QW-1:0] quo_q;
  logic [1:0]         dzero_q, full_q;
  logic               present_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_QSET) begin
      present_q <= (den_set[0] != '0);
      for (int u = 0; u < 2; u++) begin
        rem_q[u]   <= num_set[u];
        den_q[u]   <= den_set[u];
        quo_q[u]   <= '0;
        dzero_q[u] <= (den_set[u] == '0);
        full_q[u]  <= (num_set[u] >= den_set[u]);
      end
    end else if ((state_q == ST_DIV) && !div_done) begin
      for (int u = 0; u < 2; u++) begin
        logic [DW-1:0] sh;
        sh = {rem_q[u][DW-2:0], 1'b0};
        if (sh >= den_q[u]) begin
          rem_q[u] <= sh - den_q[u];
          quo_q[u] <= {quo_q[u][QW-2:0], 1'b1};
        end else begin
          rem_q[u] <= sh;
          quo_q[u] <= {quo_q[u][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (state_q == ST_QSET) begin
      step_q <= '0;
    end else if ((state_q == ST_DIV) && !div_done) begin
      step_q <= step_q + SW'(1);
    end
  end

  // half-up rounding of the extra quotient bit, capped at one
  logic [1:0][QW-1:0] ratio;
  always_comb begin
    for (int u = 0; u < 2; u++) begin
      logic [QW:0] rnd;
      rnd = {1'b0, quo_q[u]} + (QW + 1)'(1);
      if (dzero_q[u]) begin
        ratio[u] = '0;
      end else if (full_q[u]) begin
        ratio[u] = {1'b1, {FRACTION_BITS{1'b0}}};
      end else begin
        ratio[u] = rnd[QW:1];
      end
    end
  end

  // field-width views of the results
  logic [1:0][QW+RATIO_OUT_W-1:0]       ratio_ext;
  logic [NUM_FLDS-1:0][CW+CNT_OUT_W-1:0] cnt_ext;
  always_comb begin
    for (int u = 0; u < 2; u++) begin
      ratio_ext[u] = {{RATIO_OUT_W{1'b0}}, ratio[u]};
    end
    for (int f = 0; f < NUM_FLDS; f++) begin
      cnt_ext[f] = {{CNT_OUT_W{1'b0}}, cnt_q[f]};
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_valid_q, out_load;
  assign out_load    = (state_q == ST_DIV) && div_done && out_free;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      label_o       <= qlbl_q;
      volume_a_o    <= cnt_ext[FLD_A][CNT_OUT_W-1:0];
      volume_b_o    <= cnt_ext[FLD_B][CNT_OUT_W-1:0];
      overlap_o     <= cnt_ext[FLD_OV][CNT_OUT_W-1:0];
      union_count_o <= cnt_ext[FLD_UN][CNT_OUT_W-1:0];
      dice_o        <= ratio_ext[0][RATIO_OUT_W-1:0];
      jaccard_o     <= ratio_ext[1][RATIO_OUT_W-1:0];
      present_o     <= present_q;
    end
  end

endmodule

FILE: verif/label_overlap_dice_jaccard_tb.sv
// Self-checking testbench for label_overlap_dice_jaccard: per-label A/B/overlap/union
// counters with Dice and Jaccard queries, checked against an in-bench predictor.
// Depends on lodj_pkg and the label_overlap_dice_jaccard RTL.
`timescale 1ns / 1ps

module label_overlap_dice_jaccard_tb
  import lodj_pkg::*;
();

  localparam int          NUM_LABELS   = 4096;
  localparam int          FRAC_BITS    = 16;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;   // ignored by the block
  localparam int          RANDOM_ITEMS = 700;
  localparam int          LONG_HOLD    = 400;    // receiver hold-off, in cycles
  localparam int          MAX_GAP      = 13;

  // One query result as seen on the output channel
  typedef struct packed {
    logic [LABEL_W-1:0]     label;
    logic [CNT_OUT_W-1:0]   volume_a;
    logic [CNT_OUT_W-1:0]   volume_b;
    logic [CNT_OUT_W-1:0]   overlap;
    logic [CNT_OUT_W-1:0]   union_count;
    logic [RATIO_OUT_W-1:0] dice;
    logic [RATIO_OUT_W-1:0] jaccard;
    logic                   present;
  } label_report_t;

  // Scoreboard: mirrors the four counter stores and queues the label reports
  // that accepted queries must produce, in order.
  class overlap_scoreboard;
    bit [CNT_OUT_W-1:0] count_a   [NUM_LABELS];
    bit [CNT_OUT_W-1:0] count_b   [NUM_LABELS];
    bit [CNT_OUT_W-1:0] count_ov  [NUM_LABELS];
    bit [CNT_OUT_W-1:0] count_un  [NUM_LABELS];
    label_report_t      pending_reports[$];
    int                 mismatches;
    int                 reports_checked;

    // Counters stick at all ones
    static function bit [CNT_OUT_W-1:0] sat_inc(bit [CNT_OUT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    // num/den in Q.FRAC_BITS, half-up from one extra truncated bit, capped at one
    static function logic [RATIO_OUT_W-1:0] fixed_ratio(longint unsigned num,
                                                        longint unsigned den);
      longint unsigned q;
      if (den == 0) return '0;
      if (num >= den) return RATIO_OUT_W'(1) << FRAC_BITS;
      q = (num << (FRAC_BITS + 1)) / den;
      return RATIO_OUT_W'((q + 1) >> 1);
    endfunction

    static function string show(label_report_t r);
      return $sformatf("label=%0d a=%0d b=%0d ov=%0d un=%0d dice=%0d jac=%0d present=%0b",
                       r.label, r.volume_a, r.volume_b, r.overlap, r.union_count,
                       r.dice, r.jaccard, r.present);
    endfunction

    // Called once per accepted input item
    function void note_item(logic [1:0] kind, logic [LABEL_W-1:0] la,
                            logic [LABEL_W-1:0] lb);
      label_report_t   rep;
      longint unsigned vol_sum;
      case (kind)
        KIND_ACCUM: begin
          count_a[la] = sat_inc(count_a[la]);
          count_b[lb] = sat_inc(count_b[lb]);
          if (la == lb) begin
            count_ov[la] = sat_inc(count_ov[la]);
            count_un[la] = sat_inc(count_un[la]);
          end else begin
            count_un[la] = sat_inc(count_un[la]);
            count_un[lb] = sat_inc(count_un[lb]);
          end
        end
        KIND_QUERY: begin
          vol_sum         = longint'(count_a[la]) + longint'(count_b[la]);
          rep.label       = la;
          rep.volume_a    = count_a[la];
          rep.volume_b    = count_b[la];
          rep.overlap     = count_ov[la];
          rep.union_count = count_un[la];
          rep.dice        = fixed_ratio(2 * longint'(count_ov[la]), vol_sum);
          rep.jaccard     = fixed_ratio(longint'(count_ov[la]), longint'(count_un[la]));
          rep.present     = (vol_sum != 0);
          pending_reports = {pending_reports, rep};
        end
        KIND_CLEAR: begin
          for (int i = 0; i < NUM_LABELS; i++) begin
            count_a[i]  = '0;
            count_b[i]  = '0;
            count_ov[i] = '0;
            count_un[i] = '0;
          end
        end
        default: ;  // unused kind: no effect
      endcase
    endfunction

    // Called once per accepted output item
    function void check_result(label_report_t got);
      label_report_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected label report: %s", $realtime, show(got));
        return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: label report %0d differs", $realtime, reports_checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  // DUT signals; inputs start at known values
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             kind_i      = KIND_ACCUM;
  logic [LABEL_W-1:0]     label_a_i   = '0;
  logic [LABEL_W-1:0]     label_b_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [LABEL_W-1:0]     label_o;
  logic [CNT_OUT_W-1:0]   volume_a_o;
  logic [CNT_OUT_W-1:0]   volume_b_o;
  logic [CNT_OUT_W-1:0]   overlap_o;
  logic [CNT_OUT_W-1:0]   union_count_o;
  logic [RATIO_OUT_W-1:0] dice_o;
  logic [RATIO_OUT_W-1:0] jaccard_o;
  logic                   present_o;

  overlap_scoreboard sb;

  // Idle modes flip now and then so both bursts and gappy stretches occur
  bit in_idle_on     = 1'b1;
  bit out_idle_on    = 1'b1;
  bit long_hold_req  = 1'b0;
  int items_sent     = 0;
  int queries_sent   = 0;
  int clears_sent    = 0;
  int long_holds     = 0;
  int drain_pauses   = 0;

  label_overlap_dice_jaccard u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .label_a_i     (label_a_i),
    .label_b_i     (label_b_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .label_o       (label_o),
    .volume_a_o    (volume_a_o),
    .volume_b_o    (volume_b_o),
    .overlap_o     (overlap_o),
    .union_count_o (union_count_o),
    .dice_o        (dice_o),
    .jaccard_o     (jaccard_o),
    .present_o     (present_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run (reset sweep, a few clear
  // sweeps, every item with max gaps, max stalls and a full query division).
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Offer one item after a random gap, hold it until taken, then log it.
  // Returns in the time step of the accepting edge.
  task automatic send_item(input logic [1:0] kind, input logic [LABEL_W-1:0] la,
                           input logic [LABEL_W-1:0] lb);
    int gap;
    gap = in_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    label_a_i  <= la;
    label_b_i  <= lb;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_item(kind, la, lb);
    items_sent++;
    if (kind == KIND_QUERY) queries_sent++;
    if (kind == KIND_CLEAR) clears_sent++;
  endtask

  // Sender pause: nothing offered until every queued report has come back.
  // Always moves at least one edge so valid is not re-driven in this step.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    drain_pauses++;
    do @(posedge clk_i); while (sb.pending_reports.size() != 0);
  endtask

  // Mostly a handful of hot labels so counters grow and ratios get varied;
  // a share of fully random labels toggles every label bit.
  function automatic logic [LABEL_W-1:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      case ($urandom_range(0, 7))
        0: return 12'd0;
        1: return 12'd1;
        2: return 12'd2;
        3: return 12'd3;
        4: return 12'd5;
        5: return 12'd2048;
        6: return 12'd1234;
        default: return 12'd4095;
      endcase
    end
    if (r < 90) return LABEL_W'($urandom_range(0, 15));
    return LABEL_W'($urandom);
  endfunction

  // Result side: random stall before each item, one long hold-off on request
  initial begin : result_sink
    int            hold;
    label_report_t got;
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
        long_holds++;
      end else begin
        hold = out_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if ($urandom_range(0, 39) == 0) out_idle_on = !out_idle_on;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.label       = label_o;
      got.volume_a    = volume_a_o;
      got.volume_b    = volume_b_o;
      got.overlap     = overlap_o;
      got.union_count = union_count_o;
      got.dice        = dice_o;
      got.jaccard     = jaccard_o;
      got.present     = present_o;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int               r;
    int               effective;
    int               query_run;
    logic [1:0]       kind;
    logic [LABEL_W-1:0] la;
    logic [LABEL_W-1:0] lb;

    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;  // block then sweeps its store; input stalls meanwhile

    // Directed part
    send_item(KIND_QUERY, 12'd0, 12'd0);        // empty label: zero denominators
    send_item(KIND_ACCUM, 12'd0, 12'd0);        // matching labels
    send_item(KIND_ACCUM, 12'd4095, 12'd4095);  // top label
    send_item(KIND_ACCUM, 12'd0, 12'd4095);     // mismatch, both unions
    send_item(KIND_ACCUM, 12'd4095, 12'd0);
    send_item(KIND_ACCUM, 12'd4095, 12'd4095);
    send_item(KIND_QUERY, 12'd0, 12'd4095);     // label_b ignored on query
    send_item(KIND_QUERY, 12'd4095, 12'd0);
    send_item(KIND_UNUSED, 12'd0, 12'd0);       // must change nothing
    send_item(KIND_QUERY, 12'd0, 12'd0);
    send_item(KIND_ACCUM, 12'd7, 12'd9);        // present, but no overlap
    send_item(KIND_QUERY, 12'd7, 12'd0);
    send_item(KIND_QUERY, 12'd9, 12'd0);
    send_item(KIND_ACCUM, 12'd2730, 12'd1365);  // alternating bit patterns
    send_item(KIND_ACCUM, 12'd1365, 12'd1365);
    send_item(KIND_QUERY, 12'd1365, 12'd2730);
    send_item(KIND_ACCUM, 12'd3000, 12'd3000);  // dice and jaccard exactly one
    send_item(KIND_QUERY, 12'd3000, 12'd0);
    send_item(KIND_ACCUM, 12'd100, 12'd100);    // a=3 b=1 ov=1 un=3: 1/3 rounds
    send_item(KIND_ACCUM, 12'd100, 12'd101);
    send_item(KIND_ACCUM, 12'd100, 12'd102);
    send_item(KIND_QUERY, 12'd100, 12'd0);
    send_item(KIND_CLEAR, 12'd4095, 12'd4095);
    send_item(KIND_QUERY, 12'd0, 12'd0);        // store back to zero
    send_item(KIND_QUERY, 12'd4095, 12'd0);

    // Random part
    effective = 0;
    query_run = 0;
    while (effective < RANDOM_ITEMS) begin
      if (effective == 200 && query_run == 0 && long_hold_req == 1'b0 &&
          long_holds == 0) begin
        long_hold_req = 1'b1;   // receiver blocks; keep feeding queries
        query_run     = 40;
      end
      if (effective == 450 && drain_pauses == 0) wait_drained();
      if ($urandom_range(0, 39) == 0) in_idle_on = !in_idle_on;

      r = $urandom_range(0, 199);
      if (query_run > 0) begin
        query_run--;
        kind = (r < 150) ? KIND_QUERY : KIND_ACCUM;
      end else if (r == 0) begin
        kind = KIND_CLEAR;
      end else if (r < 7) begin
        kind = KIND_UNUSED;
      end else if (r < 70) begin
        kind = KIND_QUERY;
      end else begin
        kind = KIND_ACCUM;
      end

      la = pick_label();
      // Matching pairs often, so overlap counts build up
      if (kind == KIND_ACCUM && $urandom_range(0, 99) < 40) lb = la;
      else if (kind == KIND_ACCUM) lb = pick_label();
      else lb = LABEL_W'($urandom);

      send_item(kind, la, lb);
      if (kind != KIND_UNUSED) effective++;
    end

    // Drain, then a short settle window to catch stray results
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_reports.size() != 0);
    repeat (64) @(posedge clk_i);

    $display("Covered %0d items (%0d queries, %0d clears) and checked %0d label reports,",
             items_sent, queries_sent, clears_sent, sb.reports_checked);
    $display("with random gaps and stalls, %0d long receiver hold-off(s), %0d drain pause(s).",
             long_holds, drain_pauses);
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
